// File: rtl/choice_dictionary_bitmap_top_defines.svh
// Assertion macros shared by the checker of the choice dictionary block.
// Depends on nothing; the user provides i_clk and i_rst_n in scope.
`ifndef CHOICE_DICTIONARY_BITMAP_TOP_DEFINES_SVH
`define CHOICE_DICTIONARY_BITMAP_TOP_DEFINES_SVH

// Condition implies consequence at the same clock edge.
`define CDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in choice dictionary");

// Condition implies consequence at the next clock edge.
`define CDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in choice dictionary");

`endif

// File: rtl/cdb_pkg.sv
// Shared constants, types and helper functions of the choice dictionary.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package cdb_pkg;

    localparam int WORD_BITS     = 64;
    localparam int ELEMENT_WORDS = 1024;
    localparam int BLOCKS        = (ELEMENT_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W         = 16;
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int WADDR_W       = $clog2(ELEMENT_WORDS);
    localparam int BLK_W         = $clog2(BLOCKS);
    localparam int CNT_W         = $clog2(BLOCKS + 1);
    localparam int LZ_W          = $clog2(WORD_BITS + 1);
    localparam int GRP_BITS      = 8;
    localparam int GROUPS        = WORD_BITS / GRP_BITS;
    localparam int GRP_W         = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GBIT_W        = $clog2(GRP_BITS);

    // Request kinds.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_TEST   = 2'd2;
    localparam logic [1:0] KIND_CHOOSE = 2'd3;

    typedef logic [WORD_BITS-1:0] t_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic rd_item;
        logic exec;
        logic sum_cb;
        logic lz_first;
        logic rd_cw;
        logic lz_second;
        logic res_choose;
        logic res_err;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       count_zero;
        logic       clr_last;
        logic       out_free;
    } t_status;

    // Word with only the bit of position pos set, most significant bit first.
    function automatic t_word msb_bit(input logic [BIT_W-1:0] pos);
        t_word v;
        v = '0;
        v[WORD_BITS-1-int'(pos)] = 1'b1;
        return v;
    endfunction

endpackage

// File: rtl/cdb_ctrl.sv
// Controller state machine of the choice dictionary.
// Depends on cdb_pkg; drives the datapath by t_cmd and watches t_status.
`timescale 1ns / 1ps
module cdb_ctrl import cdb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_EXEC  = 4'd3;
    localparam logic [3:0] S_CSUM  = 4'd4;
    localparam logic [3:0] S_CLZ1  = 4'd5;
    localparam logic [3:0] S_CADDR = 4'd6;
    localparam logic [3:0] S_CLZ2  = 4'd7;
    localparam logic [3:0] S_CRES  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_item = 1'b1;
                if (i_status.kind == KIND_CHOOSE) begin
                    if (i_status.count_zero) begin
                        o_cmd.res_err = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_CSUM;
                    end
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_FIN;
            end
            S_CSUM: begin
                o_cmd.sum_cb = 1'b1;
                n_state = S_CLZ1;
            end
            S_CLZ1: begin
                o_cmd.lz_first = 1'b1;
                n_state = S_CADDR;
            end
            S_CADDR: begin
                o_cmd.rd_cw = 1'b1;
                n_state = S_CLZ2;
            end
            S_CLZ2: begin
                o_cmd.lz_second = 1'b1;
                n_state = S_CRES;
            end
            S_CRES: begin
                o_cmd.res_choose = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cdb_dpath.sv
// Datapath of the choice dictionary: element word memory, summary words,
// block list, leading-zero unit and output register. Depends on cdb_pkg.
`timescale 1ns / 1ps
module cdb_dpath import cdb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [1:0]       i_kind,
    input  logic [IDX_W-1:0] i_item_index,
    input  logic             i_out_stall,
    output t_status          o_status,
    output logic             o_out_valid,
    output logic             o_is_member,
    output logic [IDX_W-1:0] o_chosen_index,
    output logic             o_empty_error
);

    t_word              mem [ELEMENT_WORDS];
    t_word              r_mem_q;
    t_word              r_sum [BLOCKS];
    t_word              r_sum_q;
    logic [BLK_W-1:0]   r_list [BLOCKS];
    logic [BLK_W-1:0]   r_slot [BLOCKS];
    logic [CNT_W-1:0]   r_cnt;
    logic [WADDR_W-1:0] r_clr_cnt;
    logic [1:0]         r_kind;
    logic [IDX_W-1:0]   r_idx;
    logic [BLK_W-1:0]   r_cb;
    logic [WADDR_W:0]   r_cw;
    logic               r_lz_nz;
    logic [GRP_W-1:0]   r_lz_grp;
    logic [GRP_BITS-1:0] r_lz_byte;
    logic               r_res_member;
    logic [IDX_W-1:0]   r_res_chosen;
    logic               r_res_err;
    logic               r_out_valid;
    logic               r_out_member;
    logic [IDX_W-1:0]   r_out_chosen;
    logic               r_out_err;

    logic [WADDR_W-1:0] w;
    logic [BIT_W-1:0]   b;
    logic [BLK_W-1:0]   blk;
    logic [BIT_W-1:0]   sb;
    logic [BLK_W-1:0]   cb;
    t_word              ebit;
    t_word              sbit;
    t_word              new_word;
    t_word              new_sum;
    logic               elem_wr;
    logic [WADDR_W-1:0] wr_addr;
    t_word              wr_data;
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic [WADDR_W:0]   cw_next;
    logic [IDX_W-1:0]   e_full;
    t_word              lz_src;
    logic               lz_nz;
    logic [GRP_W-1:0]   lz_grp;
    logic [GBIT_W-1:0]  lz_bit;
    logic [LZ_W-1:0]    lz_val;
    logic [BLK_W-1:0]   rm_slot;
    logic [CNT_W-1:0]   last;
    logic [BLK_W-1:0]   mv;

    // Field split of the latched index.
    assign w   = r_idx[IDX_W-1:BIT_W];
    assign b   = r_idx[BIT_W-1:0];
    assign blk = w[WADDR_W-1:BIT_W];
    assign sb  = w[BIT_W-1:0];
    assign cb  = r_list[r_cnt[BLK_W-1:0] - 1'b1];
    assign ebit = msb_bit(b);
    assign sbit = msb_bit(sb);
    assign new_word = r_mem_q & ~ebit;
    assign new_sum  = r_sum_q & ~sbit;
    assign rm_slot  = r_slot[blk];
    assign last     = r_cnt - 1'b1;
    assign mv       = r_list[last[BLK_W-1:0]];

    // Element write enable: insert always writes, remove only when the word is listed.
    always_comb begin
        elem_wr = 1'b0;
        if (r_kind == KIND_INSERT) begin
            elem_wr = 1'b1;
        end else if (r_kind == KIND_REMOVE) begin
            elem_wr = (r_cnt != '0) && ((r_sum_q & sbit) != '0);
        end
    end

    assign wr_addr = i_cmd.clr_wr ? r_clr_cnt : w;
    assign wr_data = i_cmd.clr_wr ? '0 :
                     (r_kind == KIND_INSERT) ? (r_mem_q | ebit) : new_word;
    assign rd_en   = i_cmd.rd_item | i_cmd.rd_cw;
    assign rd_addr = i_cmd.rd_cw ? cw_next[WADDR_W-1:0] : w;

    // Element word memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || (i_cmd.exec && elem_wr)) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Leading-zero unit, first step: find the first nonzero byte.
    assign lz_src = i_cmd.lz_second ? r_mem_q : r_sum_q;
    always_ff @(posedge i_clk) begin
        if (i_cmd.lz_first || i_cmd.lz_second) begin
            r_lz_nz   <= 1'b0;
            r_lz_grp  <= '0;
            r_lz_byte <= '0;
            for (int g = GROUPS - 1; g >= 0; g--) begin
                if (lz_src[WORD_BITS-1-g*GRP_BITS -: GRP_BITS] != '0) begin
                    r_lz_nz   <= 1'b1;
                    r_lz_grp  <= GRP_W'(g);
                    r_lz_byte <= lz_src[WORD_BITS-1-g*GRP_BITS -: GRP_BITS];
                end
            end
        end
    end

    // Leading-zero unit, second step: first set bit inside that byte.
    always_comb begin
        lz_nz  = r_lz_nz;
        lz_grp = r_lz_grp;
        lz_bit = '0;
        for (int i = 0; i < GRP_BITS; i++) begin
            if (r_lz_byte[i]) lz_bit = GBIT_W'(GRP_BITS - 1 - i);
        end
        if (lz_nz) begin
            lz_val = LZ_W'({lz_grp, lz_bit});
        end else begin
            lz_val = LZ_W'(WORD_BITS);
        end
    end

    assign cw_next = (WADDR_W+1)'({r_cb, {BIT_W{1'b0}}}) + (WADDR_W+1)'(lz_val);
    assign e_full  = IDX_W'({r_cw[WADDR_W-1:0], {BIT_W{1'b0}}}) + IDX_W'(lz_val);

    // Request latch, summary read and chosen word address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_idx  <= i_item_index;
        end
        if (i_cmd.rd_item) begin
            r_sum_q <= r_sum[blk];
        end else if (i_cmd.sum_cb) begin
            r_sum_q <= r_sum[cb];
            r_cb    <= cb;
        end
        if (i_cmd.rd_cw) begin
            r_cw <= cw_next;
        end
    end

    // Summary words, block list and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int k = 0; k < BLOCKS; k++) r_sum[k] <= '0;
        end else if (i_cmd.exec) begin
            if (r_kind == KIND_INSERT) begin
                if ((r_sum_q == '0) && (r_cnt < CNT_W'(BLOCKS))) begin
                    r_list[r_cnt[BLK_W-1:0]] <= blk;
                    r_slot[blk]              <= r_cnt[BLK_W-1:0];
                    r_cnt                    <= r_cnt + 1'b1;
                end
                r_sum[blk] <= r_sum_q | sbit;
            end else if ((r_kind == KIND_REMOVE) && elem_wr && (new_word == '0)) begin
                r_sum[blk] <= new_sum;
                if (new_sum == '0) begin
                    if (CNT_W'(rm_slot) < last) begin
                        r_list[rm_slot] <= mv;
                        r_slot[mv]      <= rm_slot;
                    end
                    r_cnt <= last;
                end
            end
        end
    end

    // Result registers for the request at work.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_member <= 1'b0;
            r_res_chosen <= '0;
            r_res_err    <= 1'b0;
        end else if (i_cmd.exec) begin
            if (r_kind == KIND_TEST) r_res_member <= (r_mem_q & ebit) != '0;
            if (r_kind == KIND_REMOVE) r_res_err <= (r_cnt == '0);
        end else if (i_cmd.res_err) begin
            r_res_err <= 1'b1;
        end else if (i_cmd.res_choose) begin
            r_res_chosen <= r_cw[WADDR_W] ? '0 : e_full;
        end
    end

    // Output register; it holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_member <= r_res_member;
            r_out_chosen <= r_res_chosen;
            r_out_err    <= r_res_err;
        end
    end

    assign o_status.kind       = r_kind;
    assign o_status.count_zero = (r_cnt == '0);
    assign o_status.clr_last   = (r_clr_cnt == WADDR_W'(ELEMENT_WORDS - 1));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_is_member    = r_out_member;
    assign o_chosen_index = r_out_chosen;
    assign o_empty_error  = r_out_err;

endmodule

// File: rtl/choice_dictionary_bitmap_top.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_kind, i_item_index
// result    out        o_out_valid / i_out_stall o_is_member, o_chosen_index, o_empty_error
//
// Insert, remove and test take one read of the element and summary words, then one
// update. Choice takes two dependent reads and two passes through the two-step
// leading-zero unit; on an empty set it ends after the first read. After reset a
// clearing pass writes all 1024 words, one per cycle, before the first request is
// taken. A stalled result holds in the output register; the next request is still
// accepted but its result waits until it frees.
// Depends on cdb_pkg, cdb_ctrl and cdb_dpath.
`timescale 1ns / 1ps
module choice_dictionary_bitmap_top import cdb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_kind,
    input  logic [IDX_W-1:0] i_item_index,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_is_member,
    output logic [IDX_W-1:0] o_chosen_index,
    output logic             o_empty_error
);

    t_cmd    cmd;
    t_status status;

    // Sequencing of each request.
    cdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Stores and result path.
    cdb_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_item_index   (i_item_index),
        .i_out_stall    (i_out_stall),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_is_member    (o_is_member),
        .o_chosen_index (o_chosen_index),
        .o_empty_error  (o_empty_error)
    );

endmodule

// File: rtl/cdb_checker.sv
// Port-level checker of the choice dictionary, bound to the top level.
// Depends on cdb_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "choice_dictionary_bitmap_top_defines.svh"
module cdb_checker import cdb_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic [1:0]       i_kind,
    input logic [IDX_W-1:0] i_item_index,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_is_member,
    input logic [IDX_W-1:0] o_chosen_index,
    input logic             o_empty_error
);

    // A stalled request keeps its payload.
    `CDB_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_kind) && $stable(i_item_index))
    // A stalled result stays valid and keeps its chosen index.
    `CDB_ASSERT_NEXT(a_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_chosen_index))
    // Membership and error never show together.
    `CDB_ASSERT_NOW(a_excl, o_out_valid, !(o_is_member && o_empty_error))
    // An error result carries no chosen member.
    `CDB_ASSERT_NOW(a_err_zero, o_out_valid && o_empty_error, o_chosen_index == '0)
    // A membership answer carries no chosen member.
    `CDB_ASSERT_NOW(a_mem_zero, o_out_valid && o_is_member, o_chosen_index == '0)

endmodule

bind choice_dictionary_bitmap_top cdb_checker u_cdb_checker (.*);
